[rtl/core/b64v_pkg.sv]
package b64v_pkg;

   // Default width of the assembled value and reset value of the value limit.
   localparam int VALUE_BITS_DEFAULT = 32;
   localparam logic [7:0] MAX_VALUES_RESET = 8'd50;

   // Widths of the fixed fields.
   localparam int CHAR_BITS = 8;
   localparam int OUT_VALUE_BITS = 32;
   localparam int PEND_BITS = 13;
   localparam int PEND_CNT_BITS = 4;
   localparam int GROUP_BITS = 3;
   localparam int COUNT_BITS = 8;

   // Number of the last group slot inside one value.
   localparam logic [GROUP_BITS-1:0] LAST_GROUP = 3'd7;

   // Status codes reported with each result item.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_PARTIAL  = 2'd1,
      STATUS_TOO_MANY = 2'd2
   } status_type;

   // One result item as it travels from the decoder to the output register.
   typedef struct packed {
      logic [OUT_VALUE_BITS-1:0] value;
      logic                      value_valid;
      logic                      value_overflow;
      logic                      end_of_string;
      status_type                status;
   } result_type;

   // Maps one character to its six-bit code; characters outside the alphabet give zero.
   function automatic logic [5:0] sextet_of(input logic [CHAR_BITS-1:0] c);
      logic [5:0] code;
      code = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         code = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         code = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         code = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         code = 6'd62;
      end else if (c == 8'h2F) begin
         code = 6'd63;
      end
      return code;
   endfunction

endpackage

[rtl/core/b64v_core.sv]
module b64v_core #(
   parameter int VALUE_BITS = b64v_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [b64v_pkg::CHAR_BITS-1:0]      text_char,
   input  logic                                last_char,
   input  logic [b64v_pkg::COUNT_BITS-1:0]     max_values,
   output logic                                emit,
   output b64v_pkg::result_type                result
);
   import b64v_pkg::*;

   // Decoder state.
   logic [PEND_BITS-1:0]     pend_bits_ff, pend_bits_in;
   logic [PEND_CNT_BITS-1:0] pend_cnt_ff, pend_cnt_in;
   logic [VALUE_BITS-1:0]    acc_ff, acc_in;
   logic [GROUP_BITS-1:0]    group_ff, group_in;
   logic                     ovf_ff, ovf_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic                     stopped_ff, stopped_in;

   // Working signals of one step.
   logic [5:0]               sextet;
   logic [PEND_BITS-1:0]     shifted_bits;
   logic [PEND_BITS-1:0]     rem_mask;
   logic [PEND_CNT_BITS-1:0] cnt_sum;
   logic [PEND_CNT_BITS-1:0] cnt_rem;
   logic                     byte_ready;
   logic [7:0]               group_byte;
   logic [5:0]               shift;
   logic [VALUE_BITS+6:0]    term_wide;
   logic                     place;
   logic [VALUE_BITS-1:0]    acc_work;
   logic                     ovf_work;
   logic [63:0]              acc_wide;

   // Bit packing: append six bits and split off a byte once eight are pending.
   assign sextet       = sextet_of(text_char);
   assign shifted_bits = {pend_bits_ff[PEND_BITS-7:0], sextet};
   assign cnt_sum      = pend_cnt_ff + PEND_CNT_BITS'(6);
   assign byte_ready   = cnt_sum >= PEND_CNT_BITS'(8);
   assign cnt_rem      = cnt_sum - PEND_CNT_BITS'(8);
   assign group_byte   = 8'(shifted_bits >> cnt_rem);
   assign rem_mask     = (PEND_BITS'(1) << cnt_rem) - PEND_BITS'(1);

   // Placement of the seven group bits at weight 2^(7*group).
   assign shift     = ({3'b000, group_ff} << 3) - {3'b000, group_ff};
   assign term_wide = (VALUE_BITS+7)'(group_byte[6:0]) << shift;
   assign place     = !(group_ff == LAST_GROUP && ovf_ff);

   always_comb begin
      acc_work = acc_ff;
      ovf_work = ovf_ff;
      if (place) begin
         if (32'(shift) >= VALUE_BITS) begin
            if (group_byte[6:0] != 7'd0) begin
               ovf_work = 1'b1;
            end
         end else begin
            if (term_wide[VALUE_BITS+6:VALUE_BITS] != 7'd0) begin
               ovf_work = 1'b1;
            end
            acc_work = acc_ff | term_wide[VALUE_BITS-1:0];
         end
      end
   end

   assign acc_wide = 64'(acc_work);

   // Next state and the result item of this step.
   always_comb begin
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      acc_in       = acc_ff;
      group_in     = group_ff;
      ovf_in       = ovf_ff;
      count_in     = count_ff;
      stopped_in   = stopped_ff;
      emit         = 1'b0;
      result       = '0;
      result.status = STATUS_OK;

      if (!stopped_ff) begin
         pend_bits_in = shifted_bits;
         pend_cnt_in  = cnt_sum;
         if (byte_ready) begin
            pend_cnt_in  = cnt_rem;
            pend_bits_in = shifted_bits & rem_mask;
            if (!group_byte[7]) begin
               // The value is complete.
               emit = 1'b1;
               if (count_ff >= max_values) begin
                  stopped_in    = 1'b1;
                  result.status = STATUS_TOO_MANY;
               end else begin
                  count_in              = count_ff + COUNT_BITS'(1);
                  result.value          = acc_wide[OUT_VALUE_BITS-1:0];
                  result.value_valid    = 1'b1;
                  result.value_overflow = ovf_work;
               end
               acc_in   = '0;
               group_in = '0;
               ovf_in   = 1'b0;
            end else begin
               acc_in = acc_work;
               ovf_in = ovf_work;
               if (group_ff != LAST_GROUP) begin
                  group_in = group_ff + GROUP_BITS'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
      end

      // The last character always reports and starts a fresh string.
      if (last_char) begin
         emit                 = 1'b1;
         result.end_of_string = 1'b1;
         if (stopped_in) begin
            result.status = STATUS_TOO_MANY;
         end else if (pend_cnt_in != '0) begin
            result.status = STATUS_PARTIAL;
         end else begin
            result.status = STATUS_OK;
         end
         pend_bits_in = '0;
         pend_cnt_in  = '0;
         acc_in       = '0;
         group_in     = '0;
         ovf_in       = 1'b0;
         count_in     = '0;
         stopped_in   = 1'b0;
      end
   end

   // State registers advance once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         acc_ff       <= '0;
         group_ff     <= '0;
         ovf_ff       <= 1'b0;
         count_ff     <= '0;
         stopped_ff   <= 1'b0;
      end else if (step) begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         acc_ff       <= acc_in;
         group_ff     <= group_in;
         ovf_ff       <= ovf_in;
         count_ff     <= count_in;
         stopped_ff   <= stopped_in;
      end
   end

endmodule

[rtl/core/base64_varint_decoder_top.sv]
// An item accepted into the input register is decoded combinationally from there, and its
// result item, if any, is captured in the result register and offered on the rsp_ channel.
// Items move at one item per cycle through the decode between the input register and the
// result register; rsp_ready low stalls only items that give a result.
// Reset (synchronous, active high) empties both registers, clears the decode state and
// sets the value limit to 50.
module base64_varint_decoder_top #(
   parameter int VALUE_BITS = b64v_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [b64v_pkg::CHAR_BITS-1:0]        req_text_char,
   input  logic                                  req_last_char,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [b64v_pkg::OUT_VALUE_BITS-1:0]   rsp_value,
   output logic                                  rsp_value_valid,
   output logic                                  rsp_value_overflow,
   output logic                                  rsp_end_of_string,
   output logic [1:0]                            rsp_status,
   input  logic                                  csr_wr_en,
   input  logic [b64v_pkg::COUNT_BITS-1:0]       csr_wr_data
);
   import b64v_pkg::*;

   logic                  in_valid_ff;
   logic [CHAR_BITS-1:0]  in_char_ff;
   logic                  in_last_ff;
   logic                  out_valid_ff;
   result_type            out_result_ff;
   logic [COUNT_BITS-1:0] max_values_ff;
   logic                  emit;
   result_type            result;
   logic                  out_free;
   logic                  advance;
   logic                  req_take;

   // An item leaves the input register unless it has a result and the output is full and not being taken.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!emit || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   b64v_core #(
      .VALUE_BITS(VALUE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .text_char  (in_char_ff),
      .last_char  (in_last_ff),
      .max_values (max_values_ff),
      .emit       (emit),
      .result     (result)
   );

   // Value limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_values_ff <= MAX_VALUES_RESET;
      end else if (csr_wr_en) begin
         max_values_ff <= csr_wr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_text_char;
         in_last_ff <= req_last_char;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_value          = out_result_ff.value;
   assign rsp_value_valid    = out_result_ff.value_valid;
   assign rsp_value_overflow = out_result_ff.value_overflow;
   assign rsp_end_of_string  = out_result_ff.end_of_string;
   assign rsp_status         = out_result_ff.status;

endmodule

[test/base64_varint_decoder_top_tb.sv]
module base64_varint_decoder_top_tb;
   import b64v_pkg::*;

   localparam int VBITS = VALUE_BITS_DEFAULT;
   localparam int ITEM_GOAL = 1050;
   localparam int PHASE_ITEMS = 130;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 4;
   localparam int MAX_PRINTS = 40;

   // Kinds of rows in the directed stimulus.
   typedef enum logic [1:0] {
      ROW_MODEL = 2'd0,
      ROW_QUIET = 2'd1,
      ROW_GIVEN = 2'd2,
      ROW_LIMIT = 2'd3
   } row_kind_type;

   // One directed row; on a limit row the data byte is the new value limit.
   typedef struct packed {
      logic [7:0]   data;
      logic         is_last;
      row_kind_type kind;
      result_type   given;
   } stim_row_type;

   localparam result_type NO_RESULT = '0;
   localparam result_type ZERO_VALUE = '{value: 32'd0, value_valid: 1'b1,
      value_overflow: 1'b0, end_of_string: 1'b0, status: STATUS_OK};
   localparam result_type ZERO_VALUE_END = '{value: 32'd0, value_valid: 1'b1,
      value_overflow: 1'b0, end_of_string: 1'b1, status: STATUS_OK};
   localparam result_type CLEAN_END = '{value: 32'd0, value_valid: 1'b0,
      value_overflow: 1'b0, end_of_string: 1'b1, status: STATUS_OK};
   localparam result_type PARTIAL_END = '{value: 32'd0, value_valid: 1'b0,
      value_overflow: 1'b0, end_of_string: 1'b1, status: STATUS_PARTIAL};
   localparam result_type OVER_LIMIT = '{value: 32'd0, value_valid: 1'b0,
      value_overflow: 1'b0, end_of_string: 1'b0, status: STATUS_TOO_MANY};
   localparam result_type OVER_LIMIT_END = '{value: 32'd0, value_valid: 1'b0,
      value_overflow: 1'b0, end_of_string: 1'b1, status: STATUS_TOO_MANY};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_text_char;
   logic        req_last_char;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_value;
   logic        rsp_value_valid;
   logic        rsp_value_overflow;
   logic        rsp_end_of_string;
   logic [1:0]  rsp_status;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;

   // Decoder state as the testbench tracks it.
   logic [12:0]      pend_bits;
   logic [3:0]       pend_cnt;
   logic [VBITS-1:0] acc;
   logic [2:0]       grp;
   logic             ovf_seen;
   logic [7:0]       n_values;
   logic             halted;
   logic [7:0]       limit;

   result_type   decoded_q[$];
   stim_row_type stim_rows[$];

   int  mismatches = 0;
   int  n_items = 0;
   int  n_strings = 0;
   int  n_settings = 0;
   int  n_results = 0;
   int  n_values_seen = 0;
   int  n_overflow = 0;
   int  n_too_many = 0;
   int  n_partial = 0;
   int  idle_cycles = 0;
   bit  steady = 0;

   base64_varint_decoder_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_char     (req_text_char),
      .req_last_char     (req_last_char),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value         (rsp_value),
      .rsp_value_valid   (rsp_value_valid),
      .rsp_value_overflow(rsp_value_overflow),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_status        (rsp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Six-bit code of one text character; anything off the alphabet counts as zero.
   function automatic logic [5:0] sextet_code(input logic [7:0] ch);
      if (ch >= "A" && ch <= "Z") return 6'(ch - "A");
      if (ch >= "a" && ch <= "z") return 6'(ch - "a" + 26);
      if (ch >= "0" && ch <= "9") return 6'(ch - "0" + 52);
      if (ch == "+") return 6'd62;
      if (ch == "/") return 6'd63;
      return 6'd0;
   endfunction

   // Character for a code; zero is sometimes sent as a character off the alphabet.
   function automatic logic [7:0] char_of(input logic [5:0] code);
      logic [7:0] ch;
      if (code == 6'd0 && $urandom_range(0, 3) == 0) begin
         do ch = 8'($urandom_range(0, 255));
         while (sextet_code(ch) != 6'd0 || ch == "A");
         return ch;
      end
      if (code < 26) return 8'("A" + code);
      if (code < 52) return 8'("a" + code - 26);
      if (code < 62) return 8'("0" + code - 52);
      if (code == 6'd62) return "+";
      return "/";
   endfunction

   task automatic clear_string();
      pend_bits = '0;
      pend_cnt = '0;
      acc = '0;
      grp = '0;
      ovf_seen = 1'b0;
      n_values = '0;
      halted = 1'b0;
   endtask

   // Works out the result item, if any, that one accepted character causes.
   task automatic decode_char(input logic [7:0] ch, input logic is_last,
                              output bit emit, output result_type r);
      logic [7:0]  grp_byte;
      logic [63:0] term;
      int          shift;
      emit = 1'b0;
      r = NO_RESULT;
      if (!halted) begin
         pend_bits = {pend_bits[6:0], sextet_code(ch)};
         pend_cnt = pend_cnt + 4'd6;
         if (pend_cnt >= 4'd8) begin
            pend_cnt = pend_cnt - 4'd8;
            grp_byte = 8'(pend_bits >> pend_cnt);
            pend_bits = pend_bits & ((13'd1 << pend_cnt) - 13'd1);
            shift = 7 * grp;
            // Once a value has lost bits, the eighth group and any after it are dropped.
            if (!(grp == LAST_GROUP && ovf_seen)) begin
               if (shift >= VBITS) begin
                  if (grp_byte[6:0] != 7'd0) ovf_seen = 1'b1;
               end else begin
                  term = 64'(grp_byte[6:0]) << shift;
                  if ((term >> VBITS) != 64'd0) ovf_seen = 1'b1;
                  acc = acc | term[VBITS-1:0];
               end
            end
            if (grp_byte[7]) begin
               if (grp != LAST_GROUP) grp = grp + 3'd1;
               else ovf_seen = 1'b1;
            end else begin
               emit = 1'b1;
               if (n_values >= limit) begin
                  halted = 1'b1;
                  r.status = STATUS_TOO_MANY;
               end else begin
                  n_values = n_values + 8'd1;
                  r.value = 32'(acc);
                  r.value_valid = 1'b1;
                  r.value_overflow = ovf_seen;
               end
               acc = '0;
               grp = '0;
               ovf_seen = 1'b0;
            end
         end
      end
      // The last character always reports and starts a fresh string.
      if (is_last) begin
         emit = 1'b1;
         r.end_of_string = 1'b1;
         if (halted) r.status = STATUS_TOO_MANY;
         else if (pend_cnt != 4'd0) r.status = STATUS_PARTIAL;
         else r.status = STATUS_OK;
         clear_string();
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatches < MAX_PRINTS) $display("Mismatch at result %0d: %s", n_results, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h",
                                                  name, got, want));
   endtask

   task automatic add_row(input logic [7:0] data, input logic is_last,
                          input row_kind_type kind, input result_type given);
      stim_row_type row;
      row.data = data;
      row.is_last = is_last;
      row.kind = kind;
      row.given = given;
      stim_rows.insert(stim_rows.size(), row);
   endtask

   // Offers one character, waits for it to be taken, and records what it should cause.
   task automatic send_char(input logic [7:0] ch, input logic is_last,
                            input row_kind_type kind, input result_type given);
      bit         emit;
      result_type r;
      steady = (n_items >= 450 && n_items < 650);
      while (!steady && $urandom_range(0, 99) < 37) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_text_char = ch;
      req_last_char = is_last;
      do @(posedge clock);
      while (!req_ready);
      decode_char(ch, is_last, emit, r);
      if (kind == ROW_GIVEN) decoded_q.insert(decoded_q.size(), given);
      else if (kind == ROW_MODEL && emit) decoded_q.insert(decoded_q.size(), r);
      n_items++;
      if (is_last) n_strings++;
      @(negedge clock);
   endtask

   // Waits until the block is idle, then writes a new value limit.
   task automatic set_limit(input logic [7:0] v);
      req_valid = 1'b0;
      while (decoded_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
      limit = v;
      n_settings++;
   endtask

   // Result side: random stalls except during the steady stretch.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = steady || ($urandom_range(0, 99) >= 37);
      end
   end

   // Compares each taken result item with the oldest one still awaited.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (decoded_q.size() == 0) begin
            report_mismatch("result item with none expected");
         end else begin
            want = decoded_q.pop_front();
            check_field("value", rsp_value, want.value);
            check_field("value_valid", rsp_value_valid, want.value_valid);
            check_field("value_overflow", rsp_value_overflow, want.value_overflow);
            check_field("end_of_string", rsp_end_of_string, want.end_of_string);
            check_field("status", rsp_status, want.status);
            if (want.value_valid) n_values_seen++;
            if (want.value_overflow) n_overflow++;
            if (want.status == STATUS_TOO_MANY) n_too_many++;
            if (want.status == STATUS_PARTIAL) n_partial++;
         end
      end
   end

   // Ends the run when no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("FAIL base64_varint_decoder_top");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0] group_bytes[$];
      logic [7:0] chars[$];
      logic [6:0] payload;
      int         phase;
      int         phase_start;
      int         nvals;
      int         ngroups;
      int         pick;
      int         nb;
      int         cut;
      int unsigned bit_buf;
      bit         big_done;

      reset = 1'b1;
      req_valid = 1'b0;
      req_text_char = '0;
      req_last_char = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      limit = MAX_VALUES_RESET;
      clear_string();
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Three zero bytes: a value on every byte, the last one ends the string.
      add_row("A", 1'b0, ROW_QUIET, NO_RESULT);
      add_row("A", 1'b0, ROW_GIVEN, ZERO_VALUE);
      add_row("A", 1'b0, ROW_GIVEN, ZERO_VALUE);
      add_row("A", 1'b1, ROW_GIVEN, ZERO_VALUE_END);
      // All-ones bytes keep continuing, so the open value is dropped at the end.
      add_row("/", 1'b0, ROW_QUIET, NO_RESULT);
      add_row("/", 1'b0, ROW_QUIET, NO_RESULT);
      add_row("/", 1'b0, ROW_QUIET, NO_RESULT);
      add_row("/", 1'b1, ROW_GIVEN, CLEAN_END);
      // A single character leaves six bits over.
      add_row("z", 1'b1, ROW_GIVEN, PARTIAL_END);
      // Alphabet edges and characters outside it.
      add_row("+", 1'b0, ROW_MODEL, NO_RESULT);
      add_row("9", 1'b0, ROW_MODEL, NO_RESULT);
      add_row("0", 1'b0, ROW_MODEL, NO_RESULT);
      add_row("Z", 1'b0, ROW_MODEL, NO_RESULT);
      add_row("a", 1'b0, ROW_MODEL, NO_RESULT);
      add_row("=", 1'b0, ROW_MODEL, NO_RESULT);
      add_row(8'hFF, 1'b0, ROW_MODEL, NO_RESULT);
      add_row(8'h00, 1'b0, ROW_MODEL, NO_RESULT);
      add_row(8'h80, 1'b1, ROW_MODEL, NO_RESULT);
      // A zero limit stops on the first value and holds until the string ends.
      add_row(8'd0, 1'b0, ROW_LIMIT, NO_RESULT);
      add_row("A", 1'b0, ROW_QUIET, NO_RESULT);
      add_row("A", 1'b0, ROW_GIVEN, OVER_LIMIT);
      add_row("A", 1'b0, ROW_QUIET, NO_RESULT);
      add_row("B", 1'b1, ROW_GIVEN, OVER_LIMIT_END);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_LIMIT) set_limit(stim_rows[i].data);
         else send_char(stim_rows[i].data, stim_rows[i].is_last, stim_rows[i].kind,
                        stim_rows[i].given);
      end

      // Random strings, with the limit changed between phases.
      phase = 0;
      phase_start = n_items;
      big_done = 1'b0;
      set_limit(8'd1);
      while (n_items < ITEM_GOAL) begin
         if (n_items - phase_start >= PHASE_ITEMS) begin
            phase++;
            phase_start = n_items;
            case (phase % 6)
               0: set_limit(8'd1);
               1: set_limit(8'd255);
               2: set_limit(8'd0);
               3: set_limit(8'($urandom_range(2, 20)));
               4: set_limit(8'($urandom_range(1, 255)));
               default: set_limit(8'd3);
            endcase
         end
         group_bytes.delete();
         chars.delete();
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            // Well-formed varints, sometimes at the limit or up to two past it.
            nvals = $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0 && (limit <= 60 || !big_done)) begin
               nvals = limit + $urandom_range(0, 2);
               if (limit > 60) big_done = 1'b1;
            end
            for (int v = 0; v < nvals; v++) begin
               pick = $urandom_range(0, 99);
               if (nvals > 20 || pick < 50) ngroups = 1;
               else if (pick < 80) ngroups = $urandom_range(2, 4);
               else if (pick < 92) ngroups = 5;
               else ngroups = $urandom_range(6, 10);
               for (int g = 0; g < ngroups; g++) begin
                  case ($urandom_range(0, 2))
                     0: payload = 7'd0;
                     1: payload = 7'h7F;
                     default: payload = 7'($urandom_range(0, 127));
                  endcase
                  group_bytes.insert(group_bytes.size(), {g != ngroups - 1, payload});
               end
            end
            // Some strings are broken: cut short or left on a continuation.
            if (pick >= 0 && $urandom_range(0, 99) < 18 && group_bytes.size() > 0) begin
               if ($urandom_range(0, 1) == 0) begin
                  cut = $urandom_range(1, group_bytes.size());
                  repeat (cut) void'(group_bytes.pop_back());
               end else begin
                  group_bytes[group_bytes.size() - 1][7] = 1'b1;
               end
            end
            // Pack the bytes into six-bit codes, most significant bit first.
            bit_buf = 0;
            nb = 0;
            foreach (group_bytes[b]) begin
               bit_buf = (bit_buf << 8) | group_bytes[b];
               nb += 8;
               while (nb >= 6) begin
                  nb -= 6;
                  chars.insert(chars.size(), char_of(6'(bit_buf >> nb)));
                  bit_buf = bit_buf & ((1 << nb) - 1);
               end
            end
            if (nb > 0) chars.insert(chars.size(), char_of(6'(bit_buf << (6 - nb))));
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 2)) chars.insert(chars.size(), 8'("="));
            end
            if (chars.size() == 0) chars.insert(chars.size(), 8'("="));
         end else begin
            // Noise: any byte value at all.
            repeat ($urandom_range(1, 12)) begin
               chars.insert(chars.size(), 8'($urandom_range(0, 255)));
            end
         end
         foreach (chars[c]) send_char(chars[c], c == chars.size() - 1, ROW_MODEL, NO_RESULT);
         // Now and then hold off until every awaited result item is back.
         if ($urandom_range(0, 19) == 0) begin
            req_valid = 1'b0;
            while (decoded_q.size() != 0) @(negedge clock);
         end
      end

      req_valid = 1'b0;
      while (decoded_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES * 2) @(negedge clock);
      if (decoded_q.size() != 0) report_mismatch("result items still awaited at the end");

      $display("Sent %0d items in %0d strings over %0d limit settings.",
               n_items, n_strings, n_settings);
      $display("Checked %0d results: %0d values, %0d overflowed, %0d too-many, %0d partial.",
               n_results, n_values_seen, n_overflow, n_too_many, n_partial);
      if (mismatches == 0) begin
         $display("PASS base64_varint_decoder_top");
      end else begin
         $display("FAIL base64_varint_decoder_top");
      end
      $finish;
   end

endmodule

[base64_varint_decoder_top.f]
rtl/core/b64v_pkg.sv
rtl/core/b64v_core.sv
rtl/core/base64_varint_decoder_top.sv
test/base64_varint_decoder_top_tb.sv
